/* rtl/fba_pkg.sv */
// ----------------------------------------------------------------------------
// fba_pkg
// Shared field widths, request codes and the command and status bundles that
// pass between the allocator's controller and its datapath.
// ----------------------------------------------------------------------------
package fba_pkg;

	localparam int REQ_W        = 2;
	localparam int PAGE_FRAME_W = 12;
	localparam int ADDR_W       = 24;

	typedef enum logic [REQ_W-1:0] {
		REQ_ALLOC = 2'd0,
		REQ_FREE  = 2'd1,
		REQ_TEST  = 2'd2
	} req_e_t;

	typedef struct packed {
		logic clear;
		logic load;
		logic scan_start;
		logic scan;
		logic pick;
		logic set_oof;
		logic div_a;
		logic fix_a;
		logic div_w;
		logic fix_w;
		logic access;
		logic commit;
	} fba_cmd_t;

	typedef struct packed {
		logic pf_zero;
		logic frame_oor;
		logic scan_hit;
		logic scan_empty;
		logic clear_last;
	} fba_status_t;

endpackage

/* rtl/fba_ctrl.sv */
// ----------------------------------------------------------------------------
// fba_ctrl
// Sequencer of the frame allocator: clearing pass, request decode, bitmap
// scan, frame split and the output register's valid flag.
// ----------------------------------------------------------------------------
module fba_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [fba_pkg::REQ_W-1:0]    req_type,
	output logic                         out_valid,
	input  logic                         out_ready,
	input  fba_pkg::fba_status_t         status,
	output fba_pkg::fba_cmd_t            cmd
);
	import fba_pkg::*;

	typedef enum logic [9:0] {
		S_CLEAR  = 10'b00_0000_0001,
		S_IDLE   = 10'b00_0000_0010,
		S_DIVA   = 10'b00_0000_0100,
		S_FIXA   = 10'b00_0000_1000,
		S_DIVW   = 10'b00_0001_0000,
		S_FIXW   = 10'b00_0010_0000,
		S_ACCESS = 10'b00_0100_0000,
		S_SCAN   = 10'b00_1000_0000,
		S_PICK   = 10'b01_0000_0000,
		S_DONE   = 10'b10_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (status.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					unique case (req_e_t'(req_type))
						REQ_ALLOC: begin
							if (status.pf_zero) begin
								cmd.scan_start = 1'b1;
								state_d        = S_SCAN;
							end else begin
								state_d = S_DONE;
							end
						end
						REQ_FREE: begin
							state_d = status.pf_zero ? S_DONE : S_DIVW;
						end
						REQ_TEST: begin
							state_d = S_DIVA;
						end
						default: begin
							state_d = S_DONE;
						end
					endcase
				end
			end
			S_DIVA: begin
				cmd.div_a = 1'b1;
				state_d   = S_FIXA;
			end
			S_FIXA: begin
				cmd.fix_a = 1'b1;
				state_d   = S_DIVW;
			end
			S_DIVW: begin
				if (status.frame_oor) begin
					state_d = S_DONE;
				end else begin
					cmd.div_w = 1'b1;
					state_d   = S_FIXW;
				end
			end
			S_FIXW: begin
				cmd.fix_w = 1'b1;
				state_d   = S_ACCESS;
			end
			S_ACCESS: begin
				cmd.access = 1'b1;
				state_d    = S_DONE;
			end
			S_SCAN: begin
				if (status.scan_hit) begin
					state_d = S_PICK;
				end else if (status.scan_empty) begin
					cmd.set_oof = 1'b1;
					state_d     = S_DONE;
				end else begin
					cmd.scan = 1'b1;
				end
			end
			S_PICK: begin
				cmd.pick = 1'b1;
				state_d  = S_DONE;
			end
			S_DONE: begin
				if (slot_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("fba_ctrl: a second beat was taken while a request was in flight");

	a_commit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || out_ready))
		else $error("fba_ctrl: result committed over an untaken output beat");

	a_valid_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("fba_ctrl: output valid rose outside the completion state");

endmodule

/* rtl/fba_datapath.sv */
// ----------------------------------------------------------------------------
// fba_datapath
// Frame bitmap memory, scan pipeline, lowest-free-bit pick, constant
// dividers for the frame split, and the result and output registers.
// ----------------------------------------------------------------------------
module fba_datapath #(
	parameter int NUM_FRAMES    = 4096,
	parameter int FRAME_BYTES   = 4096,
	parameter int MAP_WORD_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  fba_pkg::fba_cmd_t                 cmd,
	output fba_pkg::fba_status_t              status,
	input  logic [fba_pkg::REQ_W-1:0]         req_type,
	input  logic [fba_pkg::PAGE_FRAME_W-1:0]  page_frame,
	input  logic                              kernel_alloc,
	input  logic                              write_allowed,
	input  logic [fba_pkg::ADDR_W-1:0]        byte_address,
	output logic [fba_pkg::PAGE_FRAME_W-1:0]  frame_number,
	output logic                              assigned,
	output logic                              present,
	output logic                              writable,
	output logic                              user_mode,
	output logic                              out_of_frames,
	output logic                              freed,
	output logic                              in_use
);
	import fba_pkg::*;

	localparam int MAP_WORDS = (NUM_FRAMES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
	localparam int WIDX_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int BIT_W     = $clog2(MAP_WORD_BITS);
	localparam int LAST_BITS = NUM_FRAMES - (MAP_WORDS - 1) * MAP_WORD_BITS;
	localparam int RA_W      = ADDR_W - $clog2(FRAME_BYTES) + 1;
	localparam int FRAME_W   = (RA_W > PAGE_FRAME_W) ? RA_W : PAGE_FRAME_W;
	localparam int RW_W      = FRAME_W - $clog2(MAP_WORD_BITS) + 1;
	localparam int PA_W      = ADDR_W + 1;
	localparam int PICK_W    = WIDX_W + BIT_W;
	localparam logic [RA_W-1:0] RECIP_A = RA_W'((64'd1 << ADDR_W) / FRAME_BYTES);
	localparam logic [RW_W-1:0] RECIP_W = RW_W'((64'd1 << FRAME_W) / MAP_WORD_BITS);

	logic [MAP_WORD_BITS-1:0] map_mem [MAP_WORDS];
	logic [MAP_WORD_BITS-1:0] rd_data_q;

	logic [REQ_W-1:0]         req_q;
	logic                     kern_q;
	logic                     wr_q;
	logic [ADDR_W-1:0]        addr_q;
	logic [FRAME_W-1:0]       frame_q;
	logic [WIDX_W-1:0]        widx_q;
	logic [BIT_W-1:0]         bit_q;
	logic [WIDX_W-1:0]        scan_idx_q;
	logic [WIDX_W-1:0]        chk_idx_q;
	logic [WIDX_W-1:0]        clr_idx_q;
	logic                     scan_left_q;
	logic                     chk_valid_q;

	logic [PAGE_FRAME_W-1:0]  res_frame_q;
	logic                     res_assigned_q;
	logic                     res_present_q;
	logic                     res_writable_q;
	logic                     res_user_q;
	logic                     res_oof_q;
	logic                     res_freed_q;
	logic                     res_in_use_q;

	logic [ADDR_W+RA_W-1:0]   prod_a;
	logic [FRAME_W-1:0]       est_a;
	logic [PA_W-1:0]          back_a;
	logic [PA_W-1:0]          rem_a;
	logic [FRAME_W+RW_W-1:0]  prod_w;
	logic [WIDX_W-1:0]        est_w;
	logic [FRAME_W-1:0]       back_w;
	logic [FRAME_W-1:0]       rem_w;
	logic                     wrap_w;
	logic [WIDX_W-1:0]        fix_word;
	logic [BIT_W-1:0]         fix_bit;

	logic                     chk_last;
	logic [MAP_WORD_BITS-1:0] eff_word;
	logic [MAP_WORD_BITS-1:0] free_bits;
	logic [MAP_WORD_BITS-1:0] low_free;
	logic [BIT_W-1:0]         pick_bit;
	logic [PICK_W-1:0]        pick_frame;

	logic                     rd_en;
	logic [WIDX_W-1:0]        rd_addr;
	logic                     wr_en;
	logic [WIDX_W-1:0]        wr_addr;
	logic [MAP_WORD_BITS-1:0] wr_data;

	// Byte address to frame: reciprocal estimate, then one correction step.
	assign prod_a = (ADDR_W+RA_W)'(addr_q) * (ADDR_W+RA_W)'(RECIP_A);
	assign est_a  = FRAME_W'(prod_a >> ADDR_W);
	assign back_a = PA_W'(frame_q) * PA_W'(FRAME_BYTES);
	assign rem_a  = PA_W'(addr_q) - back_a;

	// Frame to word and bit, the same way.
	assign prod_w   = (FRAME_W+RW_W)'(frame_q) * (FRAME_W+RW_W)'(RECIP_W);
	assign est_w    = WIDX_W'(prod_w >> FRAME_W);
	assign back_w   = FRAME_W'(widx_q) * FRAME_W'(MAP_WORD_BITS);
	assign rem_w    = frame_q - back_w;
	assign wrap_w   = rem_w >= FRAME_W'(MAP_WORD_BITS);
	assign fix_word = wrap_w ? widx_q + WIDX_W'(1) : widx_q;
	assign fix_bit  = wrap_w ? BIT_W'(rem_w - FRAME_W'(MAP_WORD_BITS)) : BIT_W'(rem_w);

	// Bits of the last word that lie beyond the frame count are treated as used.
	assign chk_last = (chk_idx_q == WIDX_W'(MAP_WORDS - 1));

	always_comb begin
		for (int j = 0; j < MAP_WORD_BITS; j++) begin
			eff_word[j] = rd_data_q[j] | (chk_last && (j >= LAST_BITS));
		end
	end

	assign free_bits = ~eff_word;
	assign low_free  = free_bits & (~free_bits + MAP_WORD_BITS'(1));

	always_comb begin
		pick_bit = '0;
		for (int j = 0; j < MAP_WORD_BITS; j++) begin
			if (low_free[j]) begin
				pick_bit = pick_bit | BIT_W'(j);
			end
		end
	end

	assign pick_frame = PICK_W'(chk_idx_q) * PICK_W'(MAP_WORD_BITS) + PICK_W'(pick_bit);

	assign status.pf_zero    = (page_frame == '0);
	assign status.frame_oor  = (32'(frame_q) >= 32'(NUM_FRAMES));
	assign status.scan_hit   = chk_valid_q && (|free_bits);
	assign status.scan_empty = !scan_left_q && !chk_valid_q;
	assign status.clear_last = (clr_idx_q == WIDX_W'(MAP_WORDS - 1));

	assign rd_en   = cmd.fix_w || (cmd.scan && scan_left_q);
	assign rd_addr = cmd.fix_w ? fix_word : scan_idx_q;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = clr_idx_q;
		wr_data = '0;
		priority if (cmd.clear) begin
			wr_en = 1'b1;
		end else if (cmd.access && (req_q == REQ_FREE)) begin
			wr_en   = 1'b1;
			wr_addr = widx_q;
			wr_data = rd_data_q & ~(MAP_WORD_BITS'(1) << bit_q);
		end else if (cmd.pick) begin
			wr_en   = 1'b1;
			wr_addr = chk_idx_q;
			wr_data = rd_data_q | low_free;
		end else begin
			wr_en = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			map_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= map_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q   <= '0;
			scan_left_q <= 1'b0;
			chk_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				clr_idx_q <= clr_idx_q + WIDX_W'(1);
			end
			if (cmd.scan_start) begin
				scan_left_q <= 1'b1;
				chk_valid_q <= 1'b0;
			end else if (cmd.scan) begin
				chk_valid_q <= scan_left_q;
				if (scan_idx_q == WIDX_W'(MAP_WORDS - 1)) begin
					scan_left_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q          <= req_type;
			kern_q         <= kernel_alloc;
			wr_q           <= write_allowed;
			addr_q         <= byte_address;
			frame_q        <= FRAME_W'(page_frame);
			res_frame_q    <= page_frame;
			res_assigned_q <= 1'b0;
			res_present_q  <= 1'b0;
			res_writable_q <= 1'b0;
			res_user_q     <= 1'b0;
			res_oof_q      <= 1'b0;
			res_freed_q    <= 1'b0;
			res_in_use_q   <= 1'b0;
		end
		if (cmd.scan_start) begin
			scan_idx_q <= '0;
		end else if (cmd.scan && scan_left_q) begin
			chk_idx_q  <= scan_idx_q;
			scan_idx_q <= scan_idx_q + WIDX_W'(1);
		end
		if (cmd.div_a) begin
			frame_q <= est_a;
		end
		if (cmd.fix_a && (rem_a >= PA_W'(FRAME_BYTES))) begin
			frame_q <= frame_q + FRAME_W'(1);
		end
		if (cmd.div_w) begin
			widx_q <= est_w;
		end
		if (cmd.fix_w) begin
			widx_q <= fix_word;
			bit_q  <= fix_bit;
		end
		if (cmd.access) begin
			if (req_q == REQ_FREE) begin
				res_freed_q <= 1'b1;
			end
			if (req_q == REQ_TEST) begin
				res_in_use_q <= rd_data_q[bit_q];
			end
		end
		if (cmd.pick) begin
			res_frame_q    <= PAGE_FRAME_W'(pick_frame);
			res_assigned_q <= 1'b1;
			res_present_q  <= 1'b1;
			res_writable_q <= wr_q;
			res_user_q     <= !kern_q;
		end
		if (cmd.set_oof) begin
			res_oof_q <= 1'b1;
		end
		if (cmd.commit) begin
			frame_number  <= res_frame_q;
			assigned      <= res_assigned_q;
			present       <= res_present_q;
			writable      <= res_writable_q;
			user_mode     <= res_user_q;
			out_of_frames <= res_oof_q;
			freed         <= res_freed_q;
			in_use        <= res_in_use_q;
		end
	end

	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clear, cmd.access, cmd.pick}))
		else $error("fba_datapath: two bitmap write sources in one cycle");

	a_frame_fix_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fix_a |-> (rem_a < PA_W'(2 * FRAME_BYTES)))
		else $error("fba_datapath: frame estimate off by more than one");

	a_word_fix_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fix_w |-> (rem_w < FRAME_W'(2 * MAP_WORD_BITS)))
		else $error("fba_datapath: word estimate off by more than one");

	a_pick_after_hit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pick |-> $past(status.scan_hit))
		else $error("fba_datapath: pick without a word holding a free frame");

endmodule

/* rtl/frame_bitmap_allocator.sv */
// ----------------------------------------------------------------------------
// frame_bitmap_allocator
// First-fit page frame allocator over a used/free bitmap held in a single-port
// memory of MAP_WORD_BITS-bit words. After reset the block clears the bitmap
// word by word and takes no beat until that is done. It then handles one
// request at a time. An allocate with a zero frame scans the bitmap one word
// per cycle. Free and test requests split the frame into word and bit with
// two-step constant dividers; a test first takes its frame from the byte
// address the same way, and a frame beyond the map is not looked up. Any other
// request goes straight to completion. Results leave through an output
// register, and a result waiting there stalls only the completion of the next
// request.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator #(
	parameter int NUM_FRAMES    = 4096,
	parameter int FRAME_BYTES   = 4096,
	parameter int MAP_WORD_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [fba_pkg::REQ_W-1:0]         req_type,
	input  logic [fba_pkg::PAGE_FRAME_W-1:0]  page_frame,
	input  logic                              kernel_alloc,
	input  logic                              write_allowed,
	input  logic [fba_pkg::ADDR_W-1:0]        byte_address,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [fba_pkg::PAGE_FRAME_W-1:0]  frame_number,
	output logic                              assigned,
	output logic                              present,
	output logic                              writable,
	output logic                              user_mode,
	output logic                              out_of_frames,
	output logic                              freed,
	output logic                              in_use
);
	import fba_pkg::*;

	fba_cmd_t    cmd;
	fba_status_t status;

	fba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	fba_datapath #(
		.NUM_FRAMES    (NUM_FRAMES),
		.FRAME_BYTES   (FRAME_BYTES),
		.MAP_WORD_BITS (MAP_WORD_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.req_type      (req_type),
		.page_frame    (page_frame),
		.kernel_alloc  (kernel_alloc),
		.write_allowed (write_allowed),
		.byte_address  (byte_address),
		.frame_number  (frame_number),
		.assigned      (assigned),
		.present       (present),
		.writable      (writable),
		.user_mode     (user_mode),
		.out_of_frames (out_of_frames),
		.freed         (freed),
		.in_use        (in_use)
	);

endmodule
